[rtl/rtcc_pkg.sv]
package rtcc_pkg;

  // Sizing
  localparam int NUM_COMPARE = 4;
  localparam int COUNT_BITS  = 24;
  localparam int DATA_W      = 32;
  localparam int SEL_W       = 5;

  // Counter limits
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] TRIG_VALUE = CNT_MAX - COUNT_BITS'(15);
  localparam logic [DATA_W-1:0]     PRESCALE_MAX = DATA_W'(4095);

  // Event enable / interrupt enable bit positions
  localparam int EN_TICK_BIT  = 0;
  localparam int EN_OVF_BIT   = 1;
  localparam int CMP_BIT_BASE = 16;

  // Request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register map
  localparam int R_START     = 0;
  localparam int R_STOP      = 1;
  localparam int R_CLEAR     = 2;
  localparam int R_TRIGOVF   = 3;
  localparam int R_EVTICK    = 4;
  localparam int R_EVOVF     = 5;
  localparam int R_EVCMP     = 6;
  localparam int R_INTENSET  = 6 + NUM_COMPARE;
  localparam int R_INTENCLR  = 7 + NUM_COMPARE;
  localparam int R_EVTEN     = 8 + NUM_COMPARE;
  localparam int R_EVTENSET  = 9 + NUM_COMPARE;
  localparam int R_EVTENCLR  = 10 + NUM_COMPARE;
  localparam int R_COUNTER   = 11 + NUM_COMPARE;
  localparam int R_PRESCALER = 12 + NUM_COMPARE;
  localparam int R_CC        = 13 + NUM_COMPARE;

  typedef struct packed {
    logic [1:0]        op;
    logic [SEL_W-1:0]  reg_sel;
    logic [DATA_W-1:0] wdata;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq_pulse;
    logic              notify;
    logic              prescaler_error;
  } out_rsp_t;

endpackage

[rtl/rtcc_core.sv]
module rtcc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  rtcc_pkg::in_req_t  req,
  output rtcc_pkg::out_rsp_t rsp
);
  import rtcc_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [DATA_W-1:0]     cc_r [NUM_COMPARE];
  logic [DATA_W-1:0]     cc_nxt [NUM_COMPARE];
  logic [DATA_W-1:0]     evcmp_r [NUM_COMPARE];
  logic [DATA_W-1:0]     evcmp_nxt [NUM_COMPARE];
  logic [DATA_W-1:0]     evten_r, evten_nxt;
  logic [DATA_W-1:0]     inten_r, inten_nxt;
  logic [DATA_W-1:0]     evtick_r, evtick_nxt;
  logic [DATA_W-1:0]     evovf_r, evovf_nxt;
  logic [DATA_W-1:0]     start_r, start_nxt;
  logic [DATA_W-1:0]     stop_r, stop_nxt;
  logic [DATA_W-1:0]     clear_r, clear_nxt;
  logic [DATA_W-1:0]     trigovf_r, trigovf_nxt;
  logic [DATA_W-1:0]     prescale_r, prescale_nxt;
  logic [DATA_W-1:0]     evtenset_r, evtenset_nxt;
  logic [DATA_W-1:0]     evtenclr_r, evtenclr_nxt;
  logic                  ovf_pend_r, ovf_pend_nxt;
  logic                  clr_pend_r, clr_pend_nxt;
  logic                  skip_r, skip_nxt;

  logic              running;
  logic [DATA_W-1:0] cnt_ext;
  logic              ovf_fire;
  logic [DATA_W-1:0] rd_data;
  int                sel_i;

  assign sel_i    = int'(req.reg_sel);
  assign cnt_ext  = DATA_W'(count_r);
  assign running  = !((stop_r != '0) && (start_r == '0));
  assign ovf_fire = ovf_pend_r && (count_r == '0) && !skip_r;

  // Read mux
  always_comb begin
    rd_data = '0;
    if (sel_i == R_START)         rd_data = start_r;
    if (sel_i == R_STOP)          rd_data = stop_r;
    if (sel_i == R_CLEAR)         rd_data = clear_r;
    if (sel_i == R_TRIGOVF)       rd_data = trigovf_r;
    if (sel_i == R_EVTICK)        rd_data = evtick_r;
    if (sel_i == R_EVOVF)         rd_data = evovf_r;
    if (sel_i == R_INTENSET || sel_i == R_INTENCLR) rd_data = inten_r;
    if (sel_i == R_EVTEN)         rd_data = evten_r;
    if (sel_i == R_EVTENSET)      rd_data = evtenset_r;
    if (sel_i == R_EVTENCLR)      rd_data = evtenclr_r;
    if (sel_i == R_COUNTER)       rd_data = cnt_ext;
    if (sel_i == R_PRESCALER)     rd_data = prescale_r;
    for (int i = 0; i < NUM_COMPARE; i++) begin
      if (sel_i == R_EVCMP + i) rd_data = evcmp_r[i];
      if (sel_i == R_CC + i)    rd_data = cc_r[i];
    end
  end

  always_comb begin
    count_nxt    = count_r;
    cc_nxt       = cc_r;
    evcmp_nxt    = evcmp_r;
    evten_nxt    = evten_r;
    inten_nxt    = inten_r;
    evtick_nxt   = evtick_r;
    evovf_nxt    = evovf_r;
    start_nxt    = start_r;
    stop_nxt     = stop_r;
    clear_nxt    = clear_r;
    trigovf_nxt  = trigovf_r;
    prescale_nxt = prescale_r;
    evtenset_nxt = evtenset_r;
    evtenclr_nxt = evtenclr_r;
    ovf_pend_nxt = ovf_pend_r;
    clr_pend_nxt = clr_pend_r;
    skip_nxt     = skip_r;
    rsp          = '0;

    if (go) begin
      unique case (req.op)
        OP_TICK: begin
          if (running) begin
            // overflow is armed one tick ahead, fires when the count wraps to zero
            if (ovf_fire) begin
              ovf_pend_nxt  = 1'b0;
              evovf_nxt     = DATA_W'(1);
              rsp.notify    = 1'b1;
              if (inten_r[EN_OVF_BIT]) rsp.irq_pulse = 1'b1;
            end else if (evten_r[EN_OVF_BIT] && count_r == CNT_MAX) begin
              ovf_pend_nxt = 1'b1;
            end
            if (evten_r[EN_TICK_BIT]) begin
              evtick_nxt = DATA_W'(1);
              if (inten_r[EN_TICK_BIT]) rsp.irq_pulse = 1'b1;
            end
            for (int i = 0; i < NUM_COMPARE; i++) begin
              if (evten_r[CMP_BIT_BASE + i] && cnt_ext == cc_r[i] && !skip_r) begin
                evcmp_nxt[i] = DATA_W'(1);
                rsp.notify   = 1'b1;
                if (inten_r[CMP_BIT_BASE + i]) rsp.irq_pulse = 1'b1;
              end
            end
            // clear wins over increment and masks matches on the next tick
            count_nxt    = clr_pend_r ? '0 : count_r + COUNT_BITS'(1);
            skip_nxt     = clr_pend_r;
            clr_pend_nxt = 1'b0;
            clear_nxt    = '0;
          end
        end
        OP_READ: begin
          rsp.rdata = rd_data;
        end
        OP_WRITE: begin
          if (sel_i == R_START) begin
            start_nxt = req.wdata;
            if (req.wdata != '0) stop_nxt = '0;
          end
          if (sel_i == R_STOP) begin
            stop_nxt = req.wdata;
            if (req.wdata != '0) start_nxt = '0;
          end
          if (sel_i == R_CLEAR) begin
            clear_nxt    = req.wdata;
            clr_pend_nxt = 1'b1;
          end
          if (sel_i == R_TRIGOVF) begin
            trigovf_nxt = req.wdata;
            count_nxt   = TRIG_VALUE;
          end
          if (sel_i == R_EVTICK) begin
            evtick_nxt = req.wdata;
            rsp.notify = 1'b1;
          end
          if (sel_i == R_EVOVF) begin
            evovf_nxt  = req.wdata;
            rsp.notify = 1'b1;
          end
          if (sel_i == R_INTENSET) inten_nxt = inten_r | req.wdata;
          if (sel_i == R_INTENCLR) inten_nxt = inten_r & ~req.wdata;
          if (sel_i == R_EVTEN)    evten_nxt = req.wdata;
          if (sel_i == R_EVTENSET) begin
            evtenset_nxt = req.wdata;
            evten_nxt    = evten_r | req.wdata;
          end
          if (sel_i == R_EVTENCLR) begin
            evtenclr_nxt = req.wdata;
            evten_nxt    = evten_r & ~req.wdata;
          end
          if (sel_i == R_PRESCALER) begin
            prescale_nxt        = req.wdata;
            rsp.prescaler_error = (req.wdata > PRESCALE_MAX);
          end
          for (int i = 0; i < NUM_COMPARE; i++) begin
            if (sel_i == R_EVCMP + i) begin
              evcmp_nxt[i] = req.wdata;
              rsp.notify   = 1'b1;
            end
            if (sel_i == R_CC + i) cc_nxt[i] = req.wdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      evten_r    <= '0;
      inten_r    <= '0;
      evtick_r   <= '0;
      evovf_r    <= '0;
      start_r    <= '0;
      stop_r     <= DATA_W'(1);
      clear_r    <= '0;
      trigovf_r  <= '0;
      prescale_r <= '0;
      evtenset_r <= '0;
      evtenclr_r <= '0;
      ovf_pend_r <= 1'b0;
      clr_pend_r <= 1'b0;
      skip_r     <= 1'b0;
      for (int i = 0; i < NUM_COMPARE; i++) begin
        cc_r[i]    <= '0;
        evcmp_r[i] <= '0;
      end
    end else begin
      count_r    <= count_nxt;
      evten_r    <= evten_nxt;
      inten_r    <= inten_nxt;
      evtick_r   <= evtick_nxt;
      evovf_r    <= evovf_nxt;
      start_r    <= start_nxt;
      stop_r     <= stop_nxt;
      clear_r    <= clear_nxt;
      trigovf_r  <= trigovf_nxt;
      prescale_r <= prescale_nxt;
      evtenset_r <= evtenset_nxt;
      evtenclr_r <= evtenclr_nxt;
      ovf_pend_r <= ovf_pend_nxt;
      clr_pend_r <= clr_pend_nxt;
      skip_r     <= skip_nxt;
      for (int i = 0; i < NUM_COMPARE; i++) begin
        cc_r[i]    <= cc_nxt[i];
        evcmp_r[i] <= evcmp_nxt[i];
      end
    end
  end

endmodule

[rtl/rtc_counter_compare_peripheral_top.sv]
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  in_req  (op, reg_sel, wdata)
// out_     out  out_valid/out_stall out_rsp (rdata, irq_pulse, notify, prescaler_error)
//
// One request per cycle sustained while out_stall is low; each request gives exactly one response.
// A request passes the request register, then core logic into the response register.
// Reset (rst_n low, synchronous) empties both stages; counter stopped, stop task reads 1.
// out_stall holds the response register; the request register still takes one
// more request, and in_stall rises only when both stages are full.
module rtc_counter_compare_peripheral_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtcc_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output rtcc_pkg::out_rsp_t out_rsp
);
  import rtcc_pkg::*;

  logic     req_valid_r;
  in_req_t  req_r;
  logic     rsp_valid_r;
  out_rsp_t rsp_r;
  out_rsp_t core_rsp;
  logic     rsp_adv;   // response register can load
  logic     core_go;   // request in flight is executed this cycle

  assign rsp_adv  = !rsp_valid_r || !out_stall;
  assign core_go  = req_valid_r && rsp_adv;
  assign in_stall = req_valid_r && !rsp_adv;

  // Request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_req;
    end
  end

  // State update happens only when the response has somewhere to go
  rtcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (core_go),
    .req   (req_r),
    .rsp   (core_rsp)
  );

  // Response stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (rsp_adv) begin
      rsp_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_go) begin
      rsp_r <= core_rsp;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

endmodule

[rtl/rtcc_checker.sv]
module rtcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rtcc_pkg::in_req_t  in_req,
  input logic               out_valid,
  input logic               out_stall,
  input rtcc_pkg::out_rsp_t out_rsp
);
  import rtcc_pkg::*;

  // held response keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // input backpressure only when the response stage is full and blocked
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without full output");

  // accepted request passes the request register and reaches the output if not blocked
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("response missing after accepted request");

  // interrupt only from ticks, prescaler error only from writes
  a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.irq_pulse |-> !out_rsp.prescaler_error && out_rsp.rdata == '0)
    else $error("mixed response kinds");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rtc_counter_compare_peripheral_top rtcc_checker u_rtcc_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rtcc_pkg::*;

  // op value 3 is reserved: the block takes it and answers with all zeros
  localparam logic [1:0] OP_NONE = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int HANG_LIMIT = 1000;
  // drain time after the last response, well above the two-stage latency
  localparam int DRAIN_CYCLES = 20;
  // from this many queued requests down, neither side idles
  localparam int CALM_LEVEL = 150;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  rtc_counter_compare_peripheral_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the peripheral's registers, kept in step with every
  // accepted request.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] rtc_cnt;
  logic [DATA_W-1:0]     rtc_cc     [NUM_COMPARE];
  logic [DATA_W-1:0]     rtc_evcmp  [NUM_COMPARE];
  logic [DATA_W-1:0]     rtc_evten;
  logic [DATA_W-1:0]     rtc_inten;
  logic [DATA_W-1:0]     rtc_evtick;
  logic [DATA_W-1:0]     rtc_evovf;
  logic [DATA_W-1:0]     rtc_start;
  logic [DATA_W-1:0]     rtc_stop;
  logic [DATA_W-1:0]     rtc_clear;
  logic [DATA_W-1:0]     rtc_trigovf;
  logic [DATA_W-1:0]     rtc_presc;
  logic [DATA_W-1:0]     rtc_evtenset_wr;
  logic [DATA_W-1:0]     rtc_evtenclr_wr;
  logic                  rtc_ovf_pend;
  logic                  rtc_clr_pend;
  logic                  rtc_skip;

  in_req_t  pending_reqs [$];
  out_rsp_t expected_rsps [$];

  int mismatches;
  int idle_cycles;
  int cyc;
  bit timed_out;

  // Computes the response to one request and advances the shadow registers.
  function automatic out_rsp_t predict_rtc_response(in_req_t r);
    out_rsp_t         rsp;
    int               sel;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] cmp_bit;
    rsp = '0;
    sel = int'(r.reg_sel);
    d   = r.wdata;
    if (r.op == OP_TICK) begin
      // stopped: stop task set and start task clear, the tick is dropped
      if (!(rtc_stop != '0 && rtc_start == '0)) begin
        if (rtc_evten[EN_OVF_BIT] && rtc_cnt == CNT_MAX) rtc_ovf_pend = 1'b1;
        if (rtc_evten[EN_TICK_BIT]) begin
          rtc_evtick = 1;
          if (rtc_inten[EN_TICK_BIT]) rsp.irq_pulse = 1'b1;
        end
        // overflow fires on the tick that sees the wrapped count
        if (rtc_ovf_pend && rtc_cnt == '0 && !rtc_skip) begin
          rtc_evovf     = 1;
          rsp.notify    = 1'b1;
          if (rtc_inten[EN_OVF_BIT]) rsp.irq_pulse = 1'b1;
          rtc_ovf_pend  = 1'b0;
        end
        for (int i = 0; i < NUM_COMPARE; i++) begin
          cmp_bit = DATA_W'(1) << (CMP_BIT_BASE + i);
          // zero-extended count: compare values above the counter range never hit
          if ((rtc_evten & cmp_bit) != '0 && DATA_W'(rtc_cnt) == rtc_cc[i] && !rtc_skip) begin
            rtc_evcmp[i] = 1;
            rsp.notify   = 1'b1;
            if ((rtc_inten & cmp_bit) != '0) rsp.irq_pulse = 1'b1;
          end
        end
        rtc_cnt = rtc_cnt + 1'b1;
        // a pending clear zeroes the count and masks matches on the next tick
        if (rtc_clr_pend) begin
          rtc_clr_pend = 1'b0;
          rtc_cnt      = '0;
          rtc_skip     = 1'b1;
        end else begin
          rtc_skip = 1'b0;
        end
        rtc_clear = '0;
      end
    end else if (r.op == OP_READ) begin
      if (sel == R_START) rsp.rdata = rtc_start;
      else if (sel == R_STOP) rsp.rdata = rtc_stop;
      else if (sel == R_CLEAR) rsp.rdata = rtc_clear;
      else if (sel == R_TRIGOVF) rsp.rdata = rtc_trigovf;
      else if (sel == R_EVTICK) rsp.rdata = rtc_evtick;
      else if (sel == R_EVOVF) rsp.rdata = rtc_evovf;
      else if (sel >= R_EVCMP && sel < R_EVCMP + NUM_COMPARE) rsp.rdata = rtc_evcmp[sel - R_EVCMP];
      else if (sel == R_INTENSET || sel == R_INTENCLR) rsp.rdata = rtc_inten;
      else if (sel == R_EVTEN) rsp.rdata = rtc_evten;
      else if (sel == R_EVTENSET) rsp.rdata = rtc_evtenset_wr;
      else if (sel == R_EVTENCLR) rsp.rdata = rtc_evtenclr_wr;
      else if (sel == R_COUNTER) rsp.rdata = DATA_W'(rtc_cnt);
      else if (sel == R_PRESCALER) rsp.rdata = rtc_presc;
      else if (sel >= R_CC && sel < R_CC + NUM_COMPARE) rsp.rdata = rtc_cc[sel - R_CC];
    end else if (r.op == OP_WRITE) begin
      if (sel == R_START) begin
        rtc_start = d;
        if (d != '0) rtc_stop = '0;
      end else if (sel == R_STOP) begin
        rtc_stop = d;
        if (d != '0) rtc_start = '0;
      end else if (sel == R_CLEAR) begin
        rtc_clear    = d;
        rtc_clr_pend = 1'b1;
      end else if (sel == R_TRIGOVF) begin
        rtc_trigovf = d;
        rtc_cnt     = TRIG_VALUE;
      end else if (sel == R_EVTICK) begin
        rtc_evtick = d;
        rsp.notify = 1'b1;
      end else if (sel == R_EVOVF) begin
        rtc_evovf  = d;
        rsp.notify = 1'b1;
      end else if (sel >= R_EVCMP && sel < R_EVCMP + NUM_COMPARE) begin
        rtc_evcmp[sel - R_EVCMP] = d;
        rsp.notify = 1'b1;
      end else if (sel == R_INTENSET) begin
        rtc_inten = rtc_inten | d;
      end else if (sel == R_INTENCLR) begin
        rtc_inten = rtc_inten & ~d;
      end else if (sel == R_EVTEN) begin
        rtc_evten = d;
      end else if (sel == R_EVTENSET) begin
        rtc_evtenset_wr = d;
        rtc_evten       = rtc_evten | d;
      end else if (sel == R_EVTENCLR) begin
        rtc_evtenclr_wr = d;
        rtc_evten       = rtc_evten & ~d;
      end else if (sel == R_PRESCALER) begin
        // out-of-range value is kept but flagged
        rtc_presc = d;
        if (d > PRESCALE_MAX) rsp.prescaler_error = 1'b1;
      end else if (sel >= R_CC && sel < R_CC + NUM_COMPARE) begin
        rtc_cc[sel - R_CC] = d;
      end
      // counter register and unknown indexes: write is dropped
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [1:0] op, int sel, logic [DATA_W-1:0] wd);
    in_req_t r;
    r.op      = op;
    r.reg_sel = SEL_W'(sel);
    r.wdata   = wd;
    pending_reqs.push_back(r);
  endtask

  // Mix of zero, small, all-ones and full-range words.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return DATA_W'($urandom_range(1, 15));
      2:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_nonzero();
    logic [DATA_W-1:0] w;
    w = rand_word();
    if (w == '0) w = 1;
    return w;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, holds them while stalled, and idles in
  // bursts. Each accepted request is run through the predictor right here.
  // ---------------------------------------------------------------------------
  int drv_gap;
  int drv_pct;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_rsps.push_back(predict_rtc_response(in_req));
      if (cyc % 64 == 0) drv_pct = pick_idle_pct();
      // a stalled request stays on the bus untouched
      if (!(in_valid && in_stall)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > CALM_LEVEL && $urandom_range(0, 99) < drv_pct) begin
          drv_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_req   <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted response against the oldest prediction and
  // throws random stall bursts at the response channel.
  // ---------------------------------------------------------------------------
  int mon_gap;
  int mon_pct;

  task automatic report_error(string what, out_rsp_t exp_rsp, out_rsp_t act_rsp);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s exp rdata=%h irq=%b notify=%b perr=%b act rdata=%h irq=%b notify=%b perr=%b",
               $realtime, what, exp_rsp.rdata, exp_rsp.irq_pulse, exp_rsp.notify,
               exp_rsp.prescaler_error, act_rsp.rdata, act_rsp.irq_pulse, act_rsp.notify,
               act_rsp.prescaler_error);
  endtask

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          report_error("unexpected response", '0, out_rsp);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_rsp.rdata !== exp_rsp.rdata || out_rsp.irq_pulse !== exp_rsp.irq_pulse ||
              out_rsp.notify !== exp_rsp.notify ||
              out_rsp.prescaler_error !== exp_rsp.prescaler_error)
            report_error("response mismatch", exp_rsp, out_rsp);
        end
      end
      if (cyc % 64 == 32) mon_pct = pick_idle_pct();
      if (mon_gap > 0) begin
        mon_gap--;
        out_stall <= 1'b1;
      end else if (pending_reqs.size() > CALM_LEVEL && $urandom_range(0, 99) < mon_pct) begin
        mon_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hang detection: counts cycles in which neither channel hands anything over
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ch;
    int n;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    cyc         = 0;
    timed_out   = 1'b0;
    drv_gap = 0;
    drv_pct = 0;
    mon_gap = 0;
    mon_pct = 0;

    rtc_cnt = '0;
    for (int i = 0; i < NUM_COMPARE; i++) begin
      rtc_cc[i]    = '0;
      rtc_evcmp[i] = '0;
    end
    rtc_evten = '0;
    rtc_inten = '0;
    rtc_evtick = '0;
    rtc_evovf  = '0;
    rtc_start  = '0;
    rtc_stop   = 1;
    rtc_clear  = '0;
    rtc_trigovf = '0;
    rtc_presc   = '0;
    rtc_evtenset_wr = '0;
    rtc_evtenclr_wr = '0;
    rtc_ovf_pend = 1'b0;
    rtc_clr_pend = 1'b0;
    rtc_skip     = 1'b0;

    // directed: reset values, stopped tick, match at zero, clear masking,
    // prescaler bounds, compare out of range, unknown op and register
    add_req(OP_READ, R_STOP, '0);
    add_req(OP_TICK, 0, '1);
    add_req(OP_WRITE, R_START, 1);
    add_req(OP_WRITE, R_EVTEN, '1);
    add_req(OP_WRITE, R_INTENSET, '1);
    add_req(OP_WRITE, R_CC, '0);
    add_req(OP_TICK, 0, '0);
    add_req(OP_WRITE, R_CC + 1, '1);
    add_req(OP_WRITE, R_TRIGOVF, '1);
    add_req(OP_READ, R_COUNTER, '0);
    add_req(OP_WRITE, R_CLEAR, '0);
    add_req(OP_READ, R_CLEAR, '0);
    add_req(OP_TICK, 0, '0);
    add_req(OP_TICK, 0, '0);
    add_req(OP_WRITE, R_PRESCALER, PRESCALE_MAX);
    add_req(OP_WRITE, R_PRESCALER, PRESCALE_MAX + 1);
    add_req(OP_READ, R_PRESCALER, '0);
    add_req(OP_WRITE, R_EVTICK, '0);
    add_req(OP_WRITE, R_INTENCLR, '1);
    add_req(OP_READ, R_INTENSET, '0);
    add_req(OP_NONE, 31, '1);
    add_req(OP_WRITE, 31, '1);
    add_req(OP_READ, 31, '0);
    add_req(OP_WRITE, R_EVTENCLR, '1);
    add_req(OP_WRITE, R_STOP, '1);

    // random: running sequences that reach overflow and compare events, mixed with other traffic
    while (pending_reqs.size() < 2025) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // raw noise across every op, index and data bit
          repeat ($urandom_range(1, 6))
            add_req(2'($urandom_range(0, 3)), $urandom_range(0, 31), rand_word());
        end
        2, 3: begin
          // run from just below the counter maximum, through the wrap when enough ticks follow
          add_req(OP_WRITE, R_START, rand_nonzero());
          add_req(OP_WRITE, R_EVTENSET,
                  DATA_W'(3) | (DATA_W'($urandom_range(0, 15)) << CMP_BIT_BASE));
          if ($urandom_range(0, 1)) add_req(OP_WRITE, R_INTENSET, rand_word());
          add_req(OP_WRITE, R_TRIGOVF, rand_word());
          n = $urandom_range(14, 22);
          for (int k = 0; k < n; k++) begin
            add_req(OP_TICK, $urandom_range(0, 31), rand_word());
            if ($urandom_range(0, 4) == 0) add_req(OP_READ, $urandom_range(0, 20), '0);
            if ($urandom_range(0, 19) == 0) add_req(OP_WRITE, R_CLEAR, rand_word());
          end
          add_req(OP_READ, R_EVOVF, '0);
        end
        4, 5: begin
          // compare channel aimed near the count
          ch = $urandom_range(0, NUM_COMPARE - 1);
          add_req(OP_WRITE, R_START, rand_nonzero());
          add_req(OP_WRITE, R_TRIGOVF, rand_word());
          case ($urandom_range(0, 2))
            0:       add_req(OP_WRITE, R_CC + ch, DATA_W'(TRIG_VALUE) + $urandom_range(0, 20));
            1:       add_req(OP_WRITE, R_CC + ch, DATA_W'($urandom_range(0, 4)));
            default: add_req(OP_WRITE, R_CC + ch, rand_word());
          endcase
          add_req(OP_WRITE, R_EVTENSET, DATA_W'(1) << (CMP_BIT_BASE + ch));
          if ($urandom_range(0, 1)) add_req(OP_WRITE, R_INTENSET, DATA_W'(1) << (CMP_BIT_BASE + ch));
          if ($urandom_range(0, 3) == 0) add_req(OP_WRITE, R_CLEAR, rand_word());
          n = $urandom_range(4, 24);
          repeat (n) add_req(OP_TICK, $urandom_range(0, 31), rand_word());
          add_req(OP_READ, R_EVCMP + ch, '0);
          if ($urandom_range(0, 1)) add_req(OP_WRITE, R_EVCMP + ch, '0);
        end
        6: begin
          case ($urandom_range(0, 3))
            0:       add_req(OP_WRITE, R_PRESCALER, PRESCALE_MAX);
            1:       add_req(OP_WRITE, R_PRESCALER, PRESCALE_MAX + 1);
            2:       add_req(OP_WRITE, R_PRESCALER, DATA_W'($urandom_range(0, 4095)));
            default: add_req(OP_WRITE, R_PRESCALER, rand_word());
          endcase
          add_req(OP_READ, R_PRESCALER, '0);
        end
        7: begin
          repeat ($urandom_range(1, 6))
            add_req($urandom_range(0, 1) ? OP_READ : OP_WRITE, $urandom_range(0, 20), rand_word());
        end
        8: begin
          // stop, ticks that are dropped if the stop word is nonzero, then a start write
          add_req(OP_WRITE, R_STOP, rand_word());
          repeat ($urandom_range(1, 4)) add_req(OP_TICK, 0, '0);
          add_req(OP_READ, R_COUNTER, '0);
          add_req(OP_WRITE, R_START, rand_word());
          add_req(OP_READ, R_START, '0);
          add_req(OP_READ, R_STOP, '0);
        end
        default: begin
          // event flags and enable masks
          add_req(OP_WRITE, $urandom_range(R_EVTICK, R_EVCMP + NUM_COMPARE - 1), rand_word());
          add_req(OP_WRITE, $urandom_range(R_INTENSET, R_EVTENCLR), rand_word());
          add_req(OP_READ, $urandom_range(R_EVTICK, R_EVTENCLR), '0);
          add_req(OP_TICK, 0, '0);
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        wait (rst_n && pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (idle_cycles < HANG_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rtcc_pkg.sv
rtl/rtcc_core.sv
rtl/rtc_counter_compare_peripheral_top.sv
rtl/rtcc_checker.sv
tb/tb.sv
